// File: rtl/bpa_pkg.sv
// Shared types, codes and widths of the bitmap page allocator.
package bpa_pkg;

	localparam int OP_W        = 2;
	localparam int ADDR_W      = 52;
	localparam int FRAME_W     = 40;
	localparam int PAGE_SHIFT  = 12;
	localparam int PAGE_CNT_W  = 13;
	localparam int STATUS_W    = 2;
	localparam int WORD_W      = 64;
	localparam int REG_SLOTS   = 3;
	localparam int REGION_W    = 2;
	localparam int RIU_W       = 2;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 40;

	localparam int DEF_REGIONS          = 3;
	localparam int DEF_PAGES_PER_REGION = 4096;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_REGIONS_IN_USE = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_REGION0_BASE   = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_REGION0_PAGES  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_REGION1_BASE   = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_REGION1_PAGES  = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_REGION2_BASE   = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] CFG_REGION2_PAGES  = 3'd6;

	typedef enum logic [OP_W-1:0] {
		OP_INIT  = 2'd0,
		OP_ALLOC = 2'd1,
		OP_FREE  = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 2'd0,
		ST_NO_FREE    = 2'd1,
		ST_MISALIGNED = 2'd2,
		ST_OUTSIDE    = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INIT_CLR,
		S_INIT_WR,
		S_ALLOC_RD,
		S_ALLOC_CHK,
		S_FREE_RD,
		S_FREE_WR
	} state_t;

	typedef struct packed {
		logic    load;
		logic    clear_valid;
		logic    init_write;
		logic    alloc_read;
		logic    alloc_commit;
		logic    free_read;
		logic    free_write;
		logic    next_word;
		logic    next_region;
		logic    finish;
		logic    take_alloc;
		status_t status;
	} ctrl_cmd_t;

	typedef struct packed {
		logic region_active;
		logic region_empty;
		logic region_last;
		logic found;
		logic last_word;
		logic misaligned;
		logic any_match;
		logic match_cur;
	} dp_stat_t;

endpackage

// File: rtl/bpa_ram.sv
// Generic simple dual-port RAM with registered read.
module bpa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 192,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: rtl/bpa_ctrl.sv
// Controller state machine of the bitmap page allocator.
module bpa_ctrl
	import bpa_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [OP_W-1:0] operation,
	input  dp_stat_t        dp_stat,
	output logic            busy,
	output ctrl_cmd_t       cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		cmd.status = ST_OK;
		busy       = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					unique case (op_t'(operation))
						OP_INIT:  state_d = S_INIT_CLR;
						OP_ALLOC: state_d = S_ALLOC_RD;
						OP_FREE:  state_d = S_FREE_RD;
						OP_NOP:   cmd.finish = 1'b1;
					endcase
				end
			end
			S_INIT_CLR: begin
				cmd.clear_valid = 1'b1;
				state_d         = S_INIT_WR;
			end
			S_INIT_WR: begin
				cmd.init_write = dp_stat.region_active && !dp_stat.region_empty;
				if (dp_stat.region_last) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end else begin
					cmd.next_region = 1'b1;
				end
			end
			S_ALLOC_RD: begin
				priority if (!dp_stat.region_active) begin
					cmd.finish = 1'b1;
					cmd.status = ST_NO_FREE;
					state_d    = S_IDLE;
				end else if (dp_stat.region_empty) begin
					cmd.next_region = 1'b1;
				end else begin
					cmd.alloc_read = 1'b1;
					state_d        = S_ALLOC_CHK;
				end
			end
			S_ALLOC_CHK: begin
				priority if (dp_stat.found) begin
					cmd.alloc_commit = 1'b1;
					cmd.finish       = 1'b1;
					cmd.take_alloc   = 1'b1;
					state_d          = S_IDLE;
				end else if (dp_stat.last_word) begin
					cmd.next_region = 1'b1;
					state_d         = S_ALLOC_RD;
				end else begin
					cmd.next_word = 1'b1;
					state_d       = S_ALLOC_RD;
				end
			end
			S_FREE_RD: begin
				priority if (dp_stat.misaligned) begin
					cmd.finish = 1'b1;
					cmd.status = ST_MISALIGNED;
					state_d    = S_IDLE;
				end else if (!dp_stat.any_match) begin
					cmd.finish = 1'b1;
					cmd.status = ST_OUTSIDE;
					state_d    = S_IDLE;
				end else if (dp_stat.match_cur) begin
					cmd.free_read = 1'b1;
					state_d       = S_FREE_WR;
				end else if (dp_stat.region_last) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end else begin
					cmd.next_region = 1'b1;
				end
			end
			S_FREE_WR: begin
				cmd.free_write = 1'b1;
				if (dp_stat.region_last) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end else begin
					cmd.next_region = 1'b1;
					state_d         = S_FREE_RD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// File: rtl/bpa_datapath.sv
// Datapath: configuration registers, bitmap memory, scan and result registers.
module bpa_datapath
	import bpa_pkg::*;
#(
	parameter int REGIONS          = DEF_REGIONS,
	parameter int PAGES_PER_REGION = DEF_PAGES_PER_REGION
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ctrl_cmd_t              cmd,
	output dp_stat_t               dp_stat,
	input  logic [ADDR_W-1:0]      free_address,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output logic                   done,
	output logic [ADDR_W-1:0]      page_address,
	output logic [STATUS_W-1:0]    status
);

	localparam int WPR     = (PAGES_PER_REGION + WORD_W - 1) / WORD_W;
	localparam int WIW     = (WPR > 1) ? $clog2(WPR) : 1;
	localparam int DEPTH   = REGIONS * WPR;
	localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int IDX_W   = WIW + 6;
	localparam int WCNT_W  = PAGE_CNT_W - 5;
	localparam logic [PAGE_CNT_W-1:0] PPR_MAX = PAGE_CNT_W'(PAGES_PER_REGION);

	function automatic logic [WORD_W-1:0] bit_sel_mask(input int k);
		logic [WORD_W-1:0] m;
		for (int i = 0; i < WORD_W; i++) begin
			m[i] = i[k];
		end
		return m;
	endfunction

	// configuration
	logic [RIU_W-1:0]      regions_in_use_q;
	logic [FRAME_W-1:0]    base_q  [REG_SLOTS];
	logic [PAGE_CNT_W-1:0] pages_q [REG_SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regions_in_use_q <= '0;
			for (int r = 0; r < REG_SLOTS; r++) begin
				base_q[r]  <= '0;
				pages_q[r] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_REGIONS_IN_USE: regions_in_use_q <= cfg_data[RIU_W-1:0];
				CFG_REGION0_BASE:   base_q[0]        <= cfg_data[FRAME_W-1:0];
				CFG_REGION0_PAGES:  pages_q[0]       <= cfg_data[PAGE_CNT_W-1:0];
				CFG_REGION1_BASE:   base_q[1]        <= cfg_data[FRAME_W-1:0];
				CFG_REGION1_PAGES:  pages_q[1]       <= cfg_data[PAGE_CNT_W-1:0];
				CFG_REGION2_BASE:   base_q[2]        <= cfg_data[FRAME_W-1:0];
				CFG_REGION2_PAGES:  pages_q[2]       <= cfg_data[PAGE_CNT_W-1:0];
				default: ;
			endcase
		end
	end

	logic [REGION_W-1:0]   n_act;
	logic [PAGE_CNT_W-1:0] size_arr [REG_SLOTS];
	logic [REG_SLOTS-1:0]  active_arr;

	assign n_act = (regions_in_use_q > RIU_W'(REGIONS)) ? REGION_W'(REGIONS) : regions_in_use_q;

	always_comb begin
		for (int r = 0; r < REG_SLOTS; r++) begin
			size_arr[r]   = (pages_q[r] > PPR_MAX) ? PPR_MAX : pages_q[r];
			active_arr[r] = (REGION_W'(r) < n_act);
		end
	end

	// scan position
	logic [REGION_W-1:0] region_q;
	logic [WIW-1:0]      word_q;
	logic [REGIONS-1:0]  match_q;
	logic [IDX_W-1:0]    free_idx_q [REGIONS];
	logic                misaligned_q;

	logic [FRAME_W-1:0]  page_in;
	logic [FRAME_W-1:0]  diff [REGIONS];
	logic [REGIONS-1:0]  match_d;

	assign page_in = free_address[ADDR_W-1:PAGE_SHIFT];

	always_comb begin
		for (int r = 0; r < REGIONS; r++) begin
			diff[r]    = page_in - base_q[r];
			match_d[r] = active_arr[r] && (page_in >= base_q[r])
				&& (diff[r] < FRAME_W'(size_arr[r]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_q     <= '0;
			word_q       <= '0;
			match_q      <= '0;
			misaligned_q <= 1'b0;
		end else if (cmd.load) begin
			region_q     <= '0;
			word_q       <= '0;
			match_q      <= match_d;
			misaligned_q <= |free_address[PAGE_SHIFT-1:0];
		end else if (cmd.next_region) begin
			region_q <= region_q + REGION_W'(1);
			word_q   <= '0;
		end else if (cmd.next_word) begin
			word_q <= word_q + WIW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int r = 0; r < REGIONS; r++) begin
				free_idx_q[r] <= diff[r][IDX_W-1:0];
			end
		end
	end

	// current region selection
	logic [PAGE_CNT_W-1:0] cur_size;
	logic [FRAME_W-1:0]    cur_base;
	logic                  cur_active;
	logic                  cur_match;
	logic [IDX_W-1:0]      cur_idx;

	always_comb begin
		cur_size   = '0;
		cur_base   = '0;
		cur_active = 1'b0;
		cur_match  = 1'b0;
		cur_idx    = '0;
		for (int r = 0; r < REGIONS; r++) begin
			if (region_q == REGION_W'(r)) begin
				cur_size   = size_arr[r];
				cur_base   = base_q[r];
				cur_active = active_arr[r];
				cur_match  = match_q[r];
				cur_idx    = free_idx_q[r];
			end
		end
	end

	// bitmap memory; per-word valid flags stand for the all-zero reset and init
	logic              rd_en;
	logic [AW-1:0]     region_base;
	logic [AW-1:0]     rd_addr;
	logic [AW-1:0]     rd_addr_s1;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [WORD_W-1:0] wr_data;
	logic [WORD_W-1:0] rd_data;
	logic [DEPTH-1:0]  valid_q;
	logic [WORD_W-1:0] eff_word;

	assign region_base = AW'(region_q) * AW'(WPR);
	assign rd_en       = cmd.alloc_read || cmd.free_read;
	assign rd_addr     = region_base
		+ (cmd.free_read ? AW'(cur_idx[IDX_W-1:6]) : AW'(word_q));

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_addr_s1 <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.clear_valid) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	assign eff_word = valid_q[rd_addr_s1] ? rd_data : '0;

	// free-bit search in the fetched word
	logic [PAGE_CNT_W-1:0] rem;
	logic [WORD_W-1:0]     limit;
	logic [WORD_W-1:0]     avail;
	logic [WORD_W-1:0]     lsb;
	logic [5:0]            bit_idx;
	logic [WCNT_W-1:0]     words_cur;
	logic [FRAME_W-1:0]    frame;

	assign rem       = cur_size - PAGE_CNT_W'({word_q, 6'b0});
	assign limit     = (rem >= PAGE_CNT_W'(WORD_W)) ? '1
		: ((WORD_W'(1) << rem[5:0]) - WORD_W'(1));
	assign avail     = ~eff_word & limit;
	assign lsb       = avail & (~avail + WORD_W'(1));
	assign words_cur = WCNT_W'((cur_size + PAGE_CNT_W'(WORD_W - 1)) >> 6);
	assign frame     = cur_base + FRAME_W'({word_q, bit_idx});

	always_comb begin
		for (int k = 0; k < 6; k++) begin
			bit_idx[k] = |(lsb & bit_sel_mask(k));
		end
	end

	always_comb begin
		wr_en   = cmd.init_write || cmd.alloc_commit || cmd.free_write;
		wr_addr = rd_addr_s1;
		wr_data = eff_word & ~(WORD_W'(1) << cur_idx[5:0]);
		if (cmd.init_write) begin
			// the in-memory bitmap of a region fits one page: mark page zero used
			wr_addr = region_base;
			wr_data = WORD_W'(1);
		end else if (cmd.alloc_commit) begin
			wr_data = eff_word | lsb;
		end
	end

	bpa_ram #(
		.WIDTH (WORD_W),
		.DEPTH (DEPTH)
	) u_bitmap (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// status to the controller
	always_comb begin
		dp_stat.region_active = cur_active;
		dp_stat.region_empty  = (cur_size == '0);
		dp_stat.region_last   = (region_q == REGION_W'(REGIONS - 1));
		dp_stat.found         = |avail;
		dp_stat.last_word     = (WCNT_W'(word_q) + WCNT_W'(1)) >= words_cur;
		dp_stat.misaligned    = misaligned_q;
		dp_stat.any_match     = |match_q;
		dp_stat.match_cur     = cur_match;
	end

	// result register
	logic                done_q;
	logic [ADDR_W-1:0]   page_address_q;
	logic [STATUS_W-1:0] status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			page_address_q <= cmd.take_alloc ? {frame, PAGE_SHIFT'(0)} : '0;
			status_q       <= cmd.status;
		end
	end

	assign done         = done_q;
	assign page_address = page_address_q;
	assign status       = status_q;

endmodule

// File: rtl/bitmap_page_allocator.sv
// Top level of the bitmap page allocator: controller plus datapath.
//
// Usage. A command (operation, free_address) is taken at a clock edge with
// start high and busy low. Exactly one result beat follows for every
// command: done is high for one cycle with page_address and status valid.
// The receiver cannot stall; done is never held.
// Configuration: cfg_valid/cfg_ready write channel, cfg_index selects the
// register (0 regions_in_use, then base page and page count of each region),
// cfg_data carries the value. cfg_ready is always high. Write only while idle.
// Sequence after accept, until done (done rises the cycle after finishing):
//   no-op code: finishes straight from idle.
//   init: valid-flag clear, then a pass over every region, writing the bitmap of each active non-empty one.
//   alloc: a bitmap read, then a search, for each word scanned; empty regions are skipped;
//     the scan ends on a hit or when no active region is left (no free page).
//   free: a pass over the regions, a read and a write-back in each matching one; misaligned or unmatched ends at once.
// The scan reads one 64-bit bitmap word at a time (registered RAM read,
// then search and write-back). busy stays high until the result beat.
// Reset (arst_n low, asynchronous) clears the configuration and all per-word
// valid flags, so the whole bitmap reads as zero with no clearing pass.
module bitmap_page_allocator
	import bpa_pkg::*;
#(
	parameter int REGIONS          = DEF_REGIONS,
	parameter int PAGES_PER_REGION = DEF_PAGES_PER_REGION
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// command channel
	input  logic                   start,
	output logic                   busy,
	input  logic [OP_W-1:0]        operation,
	input  logic [ADDR_W-1:0]      free_address,
	// configuration write channel
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	// result beat
	output logic                   done,
	output logic [ADDR_W-1:0]      page_address,
	output logic [STATUS_W-1:0]    status
);

	ctrl_cmd_t cmd;
	dp_stat_t  dp_stat;

	// registers are plain flops, so a write can always be taken
	assign cfg_ready = 1'b1;

	bpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (operation),
		.dp_stat   (dp_stat),
		.busy      (busy),
		.cmd       (cmd)
	);

	bpa_datapath #(
		.REGIONS          (REGIONS),
		.PAGES_PER_REGION (PAGES_PER_REGION)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.dp_stat      (dp_stat),
		.free_address (free_address),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.done         (done),
		.page_address (page_address),
		.status       (status)
	);

endmodule

// File: verif/bitmap_page_allocator_tb.sv
// Testbench for the bitmap page allocator: directed command table, then random phases.
module bitmap_page_allocator_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bpa_pkg::*;

	localparam int NREG       = DEF_REGIONS;
	localparam int NPG        = DEF_PAGES_PER_REGION;
	localparam int PAGE_BYTES = 4096;
	localparam int MAP_BITS   = 8;       // pages tracked per byte of in-memory map
	localparam int RAND_ITEMS = 1650;
	localparam int IDLE_LIMIT = 4000;    // watchdog limit, well above the worst alloc scan
	localparam int DIR_ROWS   = 21;
	localparam int DIR_PRESET = 6;       // rows run with the reset configuration
	localparam int MAX_SHOWN  = 10;
	// index past the last register: stored nowhere, must be harmless
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_IDX = 3'd7;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		status_t           st;
	} beat_t;

	typedef struct packed {
		op_t               op;
		logic [ADDR_W-1:0] addr;
		bit                typed;     // expected beat written out below
		logic [ADDR_W-1:0] exp_addr;
		status_t           exp_st;
	} dir_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	logic [OP_W-1:0]        operation;
	logic [ADDR_W-1:0]      free_address;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   done;
	logic [ADDR_W-1:0]      page_address;
	logic [STATUS_W-1:0]    status;

	bitmap_page_allocator #(
		.REGIONS          (NREG),
		.PAGES_PER_REGION (NPG)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.operation    (operation),
		.free_address (free_address),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.done         (done),
		.page_address (page_address),
		.status       (status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Predictor state: shadow registers and one used-bit per page
	// ---------------------------------------------------------------
	bit   [NPG-1:0]            used_map [NREG];
	logic [RIU_W-1:0]          riu_shadow;
	logic [FRAME_W-1:0]        base_shadow  [NREG];
	logic [PAGE_CNT_W-1:0]     pages_shadow [NREG];

	beat_t                     awaited_results[$];   // one entry per accepted command
	logic [ADDR_W-1:0]         held_pages[$];        // pages handed out since last init
	int unsigned               cmd_taken;
	int unsigned               cfg_taken;
	int unsigned               idle_cycles;
	int unsigned               err_cnt;

	// expectation typed in by the directed table for the command being offered
	bit                        pend_typed;
	logic [ADDR_W-1:0]         pend_addr;
	status_t                   pend_st;

	// layout to program next (full 40-bit words, upper junk allowed)
	logic [CFG_DATA_W-1:0]     lay_riu;
	logic [CFG_DATA_W-1:0]     lay_base  [NREG];
	logic [CFG_DATA_W-1:0]     lay_pages [NREG];

	dir_row_t                  dir_rows [DIR_ROWS];

	task automatic flag_error(input string msg);
		err_cnt++;
		if (err_cnt <= MAX_SHOWN) begin
			$display("[%0t] ERROR: %s", $realtime, msg);
		end
	endtask

	// page count register is clipped to the region capacity
	function automatic int unsigned region_len(input int r);
		return (pages_shadow[r] > NPG) ? NPG : int'(pages_shadow[r]);
	endfunction

	function automatic int unsigned active_count();
		return (riu_shadow > NREG) ? NREG : int'(riu_shadow);
	endfunction

	// Result of one command against the shadow bitmap; updates the bitmap.
	function automatic void compute_result(input logic [OP_W-1:0] op,
			input logic [ADDR_W-1:0] a, output logic [ADDR_W-1:0] pa, output status_t st);
		int unsigned        n;
		int unsigned        len;
		int unsigned        map_pages;
		logic [FRAME_W-1:0] pg;
		logic [FRAME_W-1:0] frame;
		bit                 found;
		bit                 hit;
		n     = active_count();
		pa    = '0;
		st    = ST_OK;
		found = 1'b0;
		hit   = 1'b0;
		case (op_t'(op))
			OP_INIT: begin
				// every region is cleared, active or not
				for (int r = 0; r < NREG; r++) used_map[r] = '0;
				for (int r = 0; r < n; r++) begin
					len       = region_len(r);
					map_pages = ((len + MAP_BITS - 1) / MAP_BITS + PAGE_BYTES - 1) / PAGE_BYTES;
					for (int j = 0; j < map_pages && j < len; j++) used_map[r][j] = 1'b1;
				end
			end
			OP_ALLOC: begin
				for (int r = 0; r < n && !found; r++) begin
					len = region_len(r);
					for (int i = 0; i < len && !found; i++) begin
						if (!used_map[r][i]) begin
							// frame number wraps in 40 bits
							frame          = base_shadow[r] + FRAME_W'(i);
							used_map[r][i] = 1'b1;
							pa             = {frame, {PAGE_SHIFT{1'b0}}};
							found          = 1'b1;
						end
					end
				end
				if (!found) st = ST_NO_FREE;
			end
			OP_FREE: begin
				if (a[PAGE_SHIFT-1:0] != '0) begin
					st = ST_MISALIGNED;
				end else begin
					pg = a[ADDR_W-1:PAGE_SHIFT];
					// no wrap in the range test; all matching regions are cleared
					for (int r = 0; r < n; r++) begin
						len = region_len(r);
						if (pg >= base_shadow[r] && 64'(pg - base_shadow[r]) < 64'(len)) begin
							used_map[r][pg - base_shadow[r]] = 1'b0;
							hit = 1'b1;
						end
					end
					if (!hit) st = ST_OUTSIDE;
				end
			end
			default: ;
		endcase
	endfunction

	// ---------------------------------------------------------------
	// Monitor: everything sampled at the rising edge.
	// A result beat is checked before a command accepted at the same
	// edge is predicted, since the beat belongs to the older command.
	// ---------------------------------------------------------------
	always @(posedge clk) begin : mon
		logic [ADDR_W-1:0] pa;
		status_t           st;
		beat_t             head;
		bit                moved;
		moved = 1'b0;
		if (arst_n) begin
			if (done === 1'b1) begin
				moved = 1'b1;
				if (awaited_results.size() == 0) begin
					flag_error($sformatf("result beat with nothing expected: addr %h status %0d",
						page_address, status));
				end else begin
					head = awaited_results.pop_front();
					if (page_address !== head.addr)
						flag_error($sformatf("page_address: expected %h, got %h",
							head.addr, page_address));
					if (status !== head.st)
						flag_error($sformatf("status: expected %0d, got %0d", head.st, status));
				end
			end
			if (start && busy === 1'b0) begin
				moved = 1'b1;
				compute_result(operation, free_address, pa, st);
				if (pend_typed) awaited_results.push_back('{pend_addr, pend_st});
				else awaited_results.push_back('{pa, st});
				if (op_t'(operation) == OP_ALLOC && st == ST_OK) held_pages.push_back(pa);
				if (op_t'(operation) == OP_INIT) held_pages.delete();
				cmd_taken++;
			end
			if (cfg_valid && cfg_ready === 1'b1) begin
				moved = 1'b1;
				case (cfg_index)
					CFG_REGIONS_IN_USE: riu_shadow      = cfg_data[RIU_W-1:0];
					CFG_REGION0_BASE:   base_shadow[0]  = cfg_data[FRAME_W-1:0];
					CFG_REGION0_PAGES:  pages_shadow[0] = cfg_data[PAGE_CNT_W-1:0];
					CFG_REGION1_BASE:   base_shadow[1]  = cfg_data[FRAME_W-1:0];
					CFG_REGION1_PAGES:  pages_shadow[1] = cfg_data[PAGE_CNT_W-1:0];
					CFG_REGION2_BASE:   base_shadow[2]  = cfg_data[FRAME_W-1:0];
					CFG_REGION2_PAGES:  pages_shadow[2] = cfg_data[PAGE_CNT_W-1:0];
					default: ;
				endcase
				cfg_taken++;
			end
		end
		// watchdog: any accepted beat of any kind resets it
		idle_cycles = moved ? 0 : idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("[%0t] watchdog: no beat for %0d cycles", $realtime, IDLE_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Driver side; all tasks are entered and left at a falling edge.
	// ---------------------------------------------------------------

	// Offer one command after an optional gap and hold it until taken.
	// start is left high so a following command needs no extra edge.
	task automatic issue_cmd(input op_t op, input logic [ADDR_W-1:0] a, input bit typed,
			input logic [ADDR_W-1:0] t_addr, input status_t t_st, input int gap);
		int unsigned seen;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pend_typed    = typed;
		pend_addr     = t_addr;
		pend_st       = t_st;
		start        <= 1'b1;
		operation    <= op;
		free_address <= a;
		seen = cmd_taken;
		do @(negedge clk); while (cmd_taken == seen);
	endtask

	task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		int unsigned seen;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		seen = cfg_taken;
		do @(negedge clk); while (cfg_taken == seen);
	endtask

	// Registers are only written with nothing in flight.
	task automatic settle();
		start <= 1'b0;
		while (awaited_results.size() != 0) @(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic program_layout();
		write_cfg(CFG_REGIONS_IN_USE, lay_riu);
		write_cfg(CFG_REGION0_BASE,   lay_base[0]);
		write_cfg(CFG_REGION0_PAGES,  lay_pages[0]);
		write_cfg(CFG_REGION1_BASE,   lay_base[1]);
		write_cfg(CFG_REGION1_PAGES,  lay_pages[1]);
		write_cfg(CFG_REGION2_BASE,   lay_base[2]);
		write_cfg(CFG_REGION2_PAGES,  lay_pages[2]);
		write_cfg(CFG_SPARE_IDX,      CFG_DATA_W'({$urandom(), $urandom()}));
		cfg_valid <= 1'b0;
	endtask

	// Random layout: mostly small regions so they fill up, a few full-size
	// or over-size counts, bases near the top of the frame space so that
	// addresses wrap, and overlapping regions.
	task automatic pick_layout(input int phase);
		int unsigned roll;
		bit          junk;
		junk = ($urandom_range(0, 3) == 0);
		if (phase == 0) begin
			// all at the top: every count over capacity, same top base
			lay_riu = 40'd3;
			for (int r = 0; r < NREG; r++) begin
				lay_base[r]  = {FRAME_W{1'b1}};
				lay_pages[r] = 40'h1FFF;
			end
		end else if (phase == 1) begin
			lay_riu = '0;
			for (int r = 0; r < NREG; r++) begin
				lay_base[r]  = '0;
				lay_pages[r] = '0;
			end
		end else begin
			roll    = $urandom_range(0, 99);
			lay_riu = (roll < 10) ? 0 : (roll < 25) ? 1 : (roll < 45) ? 2 : 3;
			for (int r = 0; r < NREG; r++) begin
				roll = $urandom_range(0, 99);
				if (roll < 10)      lay_pages[r] = 0;
				else if (roll < 20) lay_pages[r] = 64 * $urandom_range(1, 3);
				else if (roll < 25) lay_pages[r] = NPG;
				else if (roll < 30) lay_pages[r] = $urandom_range(NPG + 1, 8191);
				else                lay_pages[r] = $urandom_range(1, 150);
				roll = $urandom_range(0, 99);
				if (roll < 35)                lay_base[r] = CFG_DATA_W'({$urandom(), $urandom()});
				else if (roll < 55)           lay_base[r] = {FRAME_W{1'b1}} - $urandom_range(0, 200);
				else if (roll < 75 && r > 0)  lay_base[r] = lay_base[r-1] + $urandom_range(0, 100);
				else                          lay_base[r] = $urandom_range(0, 1000);
			end
		end
		// upper bits beyond each register's width must be dropped
		if (junk) begin
			lay_riu[CFG_DATA_W-1:RIU_W] = ($urandom() << 6) | $urandom_range(0, 63);
			for (int r = 0; r < NREG; r++)
				lay_pages[r][CFG_DATA_W-1:PAGE_CNT_W] = $urandom();
		end
	endtask

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	initial begin : stim
		int unsigned       sent;
		int unsigned       plen;
		int unsigned       pct;
		int unsigned       roll;
		int unsigned       idx;
		int unsigned       len;
		int                gap;
		int                phase;
		int                r;
		op_t               op;
		logic [ADDR_W-1:0] a;

		arst_n       = 1'b0;
		start        = 1'b0;
		operation    = OP_NOP;
		free_address = '0;
		cfg_valid    = 1'b0;
		cfg_index    = CFG_REGIONS_IN_USE;
		cfg_data     = '0;
		pend_typed   = 1'b0;
		pend_addr    = '0;
		pend_st      = ST_OK;
		riu_shadow   = '0;
		for (int k = 0; k < NREG; k++) begin
			used_map[k]     = '0;
			base_shadow[k]  = '0;
			pages_shadow[k] = '0;
		end
		cmd_taken   = 0;
		cfg_taken   = 0;
		idle_cycles = 0;
		err_cnt     = 0;

		// Directed table. First rows run with the reset configuration (no
		// active region), then a tiny layout: region 0 two pages at frame 0,
		// region 1 three pages at the top frame (its second page wraps to
		// address zero), region 2 one page, taken entirely by init.
		dir_rows = '{
			'{OP_ALLOC, 52'h0,             1'b1, 52'h0,             ST_NO_FREE},
			'{OP_FREE,  52'h0,             1'b1, 52'h0,             ST_OUTSIDE},
			'{OP_FREE,  52'hFFFFFFFFFFFFF, 1'b1, 52'h0,             ST_MISALIGNED},
			'{OP_FREE,  52'h1,             1'b1, 52'h0,             ST_MISALIGNED},
			'{OP_NOP,   52'hFFFFFFFFFFFFF, 1'b1, 52'h0,             ST_OK},
			'{OP_INIT,  52'h0,             1'b1, 52'h0,             ST_OK},
			// new layout, no init yet: bitmap still clear, page zero comes back
			'{OP_ALLOC, 52'h0,             1'b1, 52'h0,             ST_OK},
			'{OP_INIT,  52'h0,             1'b1, 52'h0,             ST_OK},
			'{OP_ALLOC, 52'h0,             1'b0, 52'h0,             ST_OK},
			'{OP_ALLOC, 52'h0,             1'b1, 52'h0,             ST_OK},
			'{OP_ALLOC, 52'h0,             1'b0, 52'h0,             ST_OK},
			'{OP_ALLOC, 52'h0,             1'b1, 52'h0,             ST_NO_FREE},
			'{OP_FREE,  52'h1000,          1'b0, 52'h0,             ST_OK},
			'{OP_FREE,  52'h1000,          1'b0, 52'h0,             ST_OK},
			'{OP_FREE,  52'hFFFFFFFFFF000, 1'b0, 52'h0,             ST_OK},
			'{OP_FREE,  52'h2000,          1'b1, 52'h0,             ST_OUTSIDE},
			'{OP_ALLOC, 52'h0,             1'b0, 52'h0,             ST_OK},
			'{OP_ALLOC, 52'h0,             1'b1, 52'hFFFFFFFFFF000, ST_OK},
			'{OP_FREE,  52'h800,           1'b1, 52'h0,             ST_MISALIGNED},
			'{OP_FREE,  52'h8000000000000, 1'b1, 52'h0,             ST_OUTSIDE},
			'{OP_NOP,   52'h0,             1'b1, 52'h0,             ST_OK}
		};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			if (i == DIR_PRESET) begin
				settle();
				lay_riu      = 40'd3;
				lay_base[0]  = 40'h0;
				lay_base[1]  = 40'hFF_FFFF_FFFF;
				lay_base[2]  = 40'h12_3456_789A;
				lay_pages[0] = 40'd2;
				lay_pages[1] = 40'd3;
				lay_pages[2] = 40'd1;
				program_layout();
			end
			issue_cmd(dir_rows[i].op, dir_rows[i].addr, dir_rows[i].typed,
				dir_rows[i].exp_addr, dir_rows[i].exp_st, 0);
		end

		// Random phases: new layout, init, then a mix dominated by allocs and
		// frees of pages actually held, with some stray or broken frees.
		sent  = 0;
		phase = 0;
		while (sent < RAND_ITEMS) begin
			settle();
			pick_layout(phase);
			program_layout();
			plen = $urandom_range(40, 120);
			for (int k = 0; k < plen && sent < RAND_ITEMS; k++) begin
				// sender gaps: light, then heavy, then none
				pct = (sent < RAND_ITEMS / 3) ? 20 : (sent < 2 * RAND_ITEMS / 3) ? 53 : 0;
				gap = ($urandom_range(0, 99) < pct) ? $urandom_range(1, 4) : 0;
				a   = ADDR_W'({$urandom(), $urandom()});
				roll = $urandom_range(0, 99);
				if (k == 0 || roll >= 96) begin
					op = (k == 0 || roll < 98) ? OP_INIT : OP_NOP;
				end else if (roll < 45) begin
					op = OP_ALLOC;
				end else if (roll < 75) begin
					op = OP_FREE;
					if (held_pages.size() != 0) begin
						idx = $urandom_range(0, held_pages.size() - 1);
						a   = held_pages[idx];
						// now and then the page is kept listed, giving a double free
						if ($urandom_range(0, 9) != 0) held_pages.delete(idx);
					end else begin
						a[PAGE_SHIFT-1:0] = '0;
					end
				end else if (roll < 87) begin
					// aligned free somewhere inside a configured region
					op  = OP_FREE;
					r   = $urandom_range(0, NREG - 1);
					len = region_len(r);
					a[PAGE_SHIFT-1:0] = '0;
					if (len != 0)
						a = {base_shadow[r] + FRAME_W'($urandom_range(0, len - 1)),
							{PAGE_SHIFT{1'b0}}};
				end else if (roll < 92) begin
					op = OP_FREE;    // random address, almost always misaligned
				end else begin
					op = OP_FREE;    // random aligned address, mostly outside
					a[PAGE_SHIFT-1:0] = '0;
				end
				issue_cmd(op, a, 1'b0, '0, ST_OK, gap);
				sent++;
			end
			phase++;
		end

		// drain: every beat in, then a short quiet stretch for strays
		start <= 1'b0;
		while (awaited_results.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (err_cnt == 0 && awaited_results.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// File: files.f
rtl/bpa_pkg.sv
rtl/bpa_ram.sv
rtl/bpa_ctrl.sv
rtl/bpa_datapath.sv
rtl/bitmap_page_allocator.sv
verif/bitmap_page_allocator_tb.sv
